// File: design/lict_pkg.sv
// ============================================================================
// lict_pkg
// Shared types and constants for the level to item count table: beat
// layouts, the per-sensor entry record, operation codes and controller states.
// ============================================================================
package lict_pkg;

    // beat widths on the stream ports
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;
    localparam int OP_W        = 3;

    // iterative divider: one quotient bit per step
    localparam int DIVIDEND_W  = 14;
    localparam int DIVISOR_W   = 8;
    localparam int STEP_W      = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    // offset clamp limits
    localparam logic signed [7:0] OFFSET_MIN = -8'sd50;
    localparam logic signed [7:0] OFFSET_MAX = 8'sd50;

    // operation codes carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_QUERY    = 3'd0,
        OP_PRESENCE = 3'd1,
        OP_READING  = 3'd2,
        OP_LIMITS   = 3'd3,
        OP_OFFSET   = 3'd4
    } op_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_DIV,
        ST_DONE
    } state_t;

    // input beat, lowest field in the lowest bits
    typedef struct packed {
        logic                pad;
        logic signed [7:0]   offset_request;
        logic [7:0]          capacity;
        logic [7:0]          item_height_mm;
        logic [12:0]         full_distance_mm;
        logic                reading_valid;
        logic signed [13:0]  level_mm;
        logic signed [13:0]  raw_mm;
        logic                present_flag;
        logic [3:0]          index;
    } item_t;

    // result beat, lowest field in the lowest bits
    typedef struct packed {
        logic [1:0]          pad;
        logic                full_flag;
        logic                empty_flag;
        logic signed [8:0]   item_count;
        logic signed [13:0]  stored_level_mm;
        logic signed [13:0]  stored_raw_mm;
        logic                is_valid;
        logic                is_present;
        logic                accepted;
        logic [3:0]          entry_index;
    } result_t;

    // one table entry as held in the memory
    typedef struct packed {
        logic                present;
        logic                valid;
        logic signed [13:0]  raw_mm;
        logic signed [13:0]  level_mm;
        logic signed [8:0]   count;
        logic                empty;
        logic                full;
        logic [12:0]         full_dist;
        logic [7:0]          height;
        logic [7:0]          cap;
        logic signed [6:0]   offset;
    } entry_t;

    // divider handshake
    typedef struct packed {
        logic                     start;
        logic [DIVIDEND_W-1:0]    dividend;
        logic [DIVISOR_W-1:0]     divisor;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic [DIVIDEND_W-1:0]    quotient;
    } div_rsp_t;

endpackage

// File: design/lict_ram.sv
// ============================================================================
// lict_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ============================================================================
module lict_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/lict_div.sv
// ============================================================================
// lict_div
// Restoring unsigned divider: 14-bit dividend by 8-bit divisor, one quotient
// bit per cycle, done pulses for one cycle after the last step.
// ============================================================================
module lict_div (
    input  logic                clk,
    input  logic                rst_n,
    input  lict_pkg::div_req_t  req,
    output lict_pkg::div_rsp_t  rsp
);
    import lict_pkg::*;

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    // one trial subtraction
    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    // step control
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next  = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: design/level_to_item_count_table.sv
// ============================================================================
// level_to_item_count_table
// Per-sensor level table: presence, last reading, limits and offset per entry,
// with the item count worked out again after each reading, limit or offset change.
// ============================================================================
// Usage
//   s_* channel: one command beat; s_tuser carries the operation, s_tdata the
//   index and the operand fields. m_* channel: one result beat per command,
//   reporting the addressed entry after the operation.
//   An entry lives in one memory word (read, modify, write back). A command
//   that works out the count passes through these steps from acceptance to
//   its result beat: the memory read at acceptance, an apply step, 14 steps
//   in the bit-serial divider that works out the items removed, a step to
//   form the count, and a step to write back and load the result register.
//   Other in-range commands skip the divider; an out-of-range index skips
//   the memory and the divider.
//   One command is in flight at a time; the next can be taken in the cycle
//   in which the previous result first sits in the output register, even if
//   that result still waits.
//   A stalled receiver holds the result register; the finished command then
//   waits (and holds back the next) until m_tready frees the register.
//   Reset empties the output register and marks every entry unwritten, so
//   each entry reads with its reset values until first written.
// ============================================================================
module level_to_item_count_table #(
    parameter int SENSOR_COUNT        = 8,
    parameter int DEFAULT_FULL_DIST   = 30,
    parameter int DEFAULT_ITEM_HEIGHT = 5,
    parameter int DEFAULT_CAPACITY    = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // index, present_flag, raw_mm, level_mm, reading_valid,
    // full_distance_mm, item_height_mm, capacity, offset_request, zero pad
    input  logic [lict_pkg::IN_TDATA_W-1:0]    s_tdata,
    // operation
    input  logic [lict_pkg::OP_W-1:0]          s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // entry_index, accepted, is_present, is_valid, stored_raw_mm,
    // stored_level_mm, item_count, empty_flag, full_flag, zero pad
    output logic [lict_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import lict_pkg::*;

    localparam int AW      = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int ENTRY_W = $bits(entry_t);

    state_t   state_reg, state_next;

    item_t    item_reg;
    logic [OP_W-1:0] op_reg;
    logic     bad_reg;
    logic     ok_reg, ok_next;
    entry_t   entry_reg, entry_next;
    logic [SENSOR_COUNT-1:0] written_reg;

    logic     out_valid_reg;
    result_t  out_data_reg;
    result_t  result;

    item_t    in_item;
    logic     in_good;
    logic [AW-1:0] idx;

    logic     s_ready_c;
    logic     ram_re;
    logic     ram_we;
    logic     apply_load;
    logic     count_load;
    logic     out_load;

    logic [ENTRY_W-1:0] ram_rdata;
    entry_t   reset_entry;
    entry_t   src;
    entry_t   mod;
    logic     recomp;
    logic     need_div;
    logic signed [15:0] num_w;
    logic signed [15:0] cnt_w;
    logic [7:0] cnt_clamped;

    div_req_t div_req;
    div_rsp_t div_rsp;

    assign in_item = item_t'(s_tdata);
    assign in_good = ({1'b0, in_item.index} < 5'(SENSOR_COUNT));
    assign idx     = item_reg.index[AW-1:0];

    // values an entry holds before its first write
    always_comb
    begin
        reset_entry             = '0;
        reset_entry.raw_mm      = -14'sd1;
        reset_entry.level_mm    = -14'sd1;
        reset_entry.count       = -9'sd1;
        reset_entry.full_dist   = 13'(DEFAULT_FULL_DIST);
        reset_entry.height      = 8'(DEFAULT_ITEM_HEIGHT);
        reset_entry.cap         = 8'(DEFAULT_CAPACITY);
    end

    // entry memory
    lict_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SENSOR_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx),
        .wdata (entry_reg),
        .re    (ram_re),
        .raddr (in_item.index[AW-1:0]),
        .rdata (ram_rdata)
    );

    // apply the operation to the entry read back
    always_comb
    begin
        src     = written_reg[idx] ? entry_t'(ram_rdata) : reset_entry;
        mod     = src;
        recomp  = 1'b0;
        ok_next = 1'b1;
        unique case (op_reg)
            OP_QUERY:
            begin
                mod = src;
            end
            OP_PRESENCE:
            begin
                mod.present = item_reg.present_flag;
                if (!item_reg.present_flag)
                begin
                    mod.valid       = 1'b0;
                    mod.raw_mm      = -14'sd1;
                    mod.level_mm    = -14'sd1;
                    mod.count       = -9'sd1;
                    mod.empty       = 1'b0;
                    mod.full        = 1'b0;
                end
            end
            OP_READING:
            begin
                mod.raw_mm      = item_reg.raw_mm;
                mod.level_mm    = item_reg.level_mm;
                mod.valid       = item_reg.reading_valid;
                recomp          = 1'b1;
            end
            OP_LIMITS:
            begin
                if (item_reg.full_distance_mm != '0)
                begin
                    mod.full_dist = item_reg.full_distance_mm;
                end
                if (item_reg.item_height_mm != '0)
                begin
                    mod.height = item_reg.item_height_mm;
                end
                if (item_reg.capacity != '0)
                begin
                    mod.cap = item_reg.capacity;
                end
                recomp = 1'b1;
            end
            OP_OFFSET:
            begin
                if (item_reg.offset_request < OFFSET_MIN)
                begin
                    mod.offset = OFFSET_MIN[6:0];
                end
                else if (item_reg.offset_request > OFFSET_MAX)
                begin
                    mod.offset = OFFSET_MAX[6:0];
                end
                else
                begin
                    mod.offset = item_reg.offset_request[6:0];
                end
                recomp = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase

        // no usable reading: count unknown
        need_div = recomp && mod.valid && !mod.level_mm[13];
        if (recomp && !need_div)
        begin
            mod.count = -9'sd1;
            mod.empty = 1'b0;
            mod.full  = 1'b0;
        end
    end

    // rounded numerator for the removed-item division
    assign num_w = 16'(mod.level_mm) - $signed({3'b000, mod.full_dist})
                 + $signed({9'd0, mod.height[7:1]});

    assign div_req.start    = apply_load && need_div;
    assign div_req.dividend = (num_w > 16'sd0) ? num_w[DIVIDEND_W-1:0] : '0;
    assign div_req.divisor  = mod.height;

    lict_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // count = capacity - removed + offset, clamped to 0 .. capacity
    assign cnt_w = $signed({8'd0, entry_reg.cap})
                 - $signed({2'b00, div_rsp.quotient})
                 + 16'(entry_reg.offset);

    always_comb
    begin
        if (cnt_w < 16'sd0)
        begin
            cnt_clamped = '0;
        end
        else if (cnt_w > $signed({8'd0, entry_reg.cap}))
        begin
            cnt_clamped = entry_reg.cap;
        end
        else
        begin
            cnt_clamped = cnt_w[7:0];
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (apply_load)
        begin
            entry_next = mod;
        end
        else if (count_load)
        begin
            entry_next.count = $signed({1'b0, cnt_clamped});
            entry_next.empty = (cnt_clamped == '0);
            entry_next.full  = (cnt_clamped == entry_reg.cap);
        end
    end

    // result beat
    always_comb
    begin
        result             = '0;
        result.entry_index = item_reg.index;
        if (!bad_reg)
        begin
            result.accepted           = ok_reg;
            result.is_present         = entry_reg.present;
            result.is_valid           = entry_reg.valid;
            result.stored_raw_mm      = entry_reg.raw_mm;
            result.stored_level_mm    = entry_reg.level_mm;
            result.item_count         = entry_reg.count;
            result.empty_flag         = entry_reg.empty;
            result.full_flag          = entry_reg.full;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = in_good ? ST_APPLY : ST_DONE;
                end
            end
            ST_APPLY:
            begin
                state_next = need_div ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_ready_c  = 1'b0;
        ram_re     = 1'b0;
        ram_we     = 1'b0;
        apply_load = 1'b0;
        count_load = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_ready_c = 1'b1;
                ram_re    = s_tvalid && in_good;
            end
            ST_APPLY:
            begin
                apply_load = 1'b1;
            end
            ST_DIV:
            begin
                count_load = div_rsp.done;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || m_tready;
                ram_we   = out_load && !bad_reg && ok_reg;
            end
            default:
            begin
                s_ready_c = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            written_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                written_reg[idx] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_ready_c && s_tvalid)
        begin
            item_reg <= in_item;
            op_reg   <= s_tuser;
            bad_reg  <= !in_good;
        end
        if (apply_load)
        begin
            ok_reg <= ok_next;
        end
        entry_reg <= entry_next;
        if (out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign s_tready = s_ready_c;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // write-back only when a command finishes
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_DONE) && !bad_reg)
        else $error("entry write outside completion");

    // divider is idle whenever a new command can be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !div_rsp.busy)
        else $error("divider busy while idle");

    // waiting on the divider means it is running or just finished
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_rsp.busy || div_rsp.done))
        else $error("waiting on an idle divider");

    // a worked-out count is never negative and sets empty exactly at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_load |=> !entry_reg.count[8]
                        && (entry_reg.empty == (entry_reg.count == 9'sd0))))
        else $error("count out of range");

endmodule
